// ===== rtl/plt_pkg.sv =====
// Shared types and constants for the packet latency tracker.
`default_nettype none
package plt_pkg;
  localparam int unsigned DefPoolDepth = 1024;
  localparam logic [2:0] REQ_TX_POST = 3'd0;
  localparam logic [2:0] REQ_TX_DONE = 3'd1;
  localparam logic [2:0] REQ_RX_START = 3'd2;
  localparam logic [2:0] REQ_RX_DONE = 3'd3;
  localparam logic [2:0] REQ_READ = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;
  localparam logic [2:0] OP_BAD_REQ = 3'd6;
  localparam logic [2:0] OP_DISABLED = 3'd7;
  localparam logic [2:0] STS_OK = 3'd0;
  localparam logic [2:0] STS_DISABLED = 3'd1;
  localparam logic [2:0] STS_FULL = 3'd2;
  localparam logic [2:0] STS_NO_MATCH = 3'd3;
  localparam logic [2:0] STS_EMPTY = 3'd4;
  localparam logic [1:0] SST_FREE = 2'd0;
  localparam logic [1:0] SST_INFLIGHT = 2'd1;
  localparam logic [1:0] SST_DONE_TX = 2'd2;
  localparam logic [1:0] SST_DONE_RX = 2'd3;
  localparam logic [10:0] QLEN_MAX = 11'd2047;
  localparam logic [31:0] RX_MATCH_ID = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0] req_type;
    logic [63:0] pkt_handle;
    logic [31:0] pkt_id;
    logic [31:0] event_time;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic result_kind;
    logic [31:0] latency;
    logic [10:0] queue_len;
  } rsp_t;

  // Command handed from front to back.
  typedef struct packed {
    logic [2:0] op;
    logic [63:0] pkt_handle;
    logic [31:0] pkt_id;
    logic [31:0] event_time;
  } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/plt_if.sv =====
// Valid/ready channel interfaces.
`default_nettype none
interface plt_req_if;
  logic valid;
  logic ready;
  plt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plt_rsp_if;
  logic valid;
  logic ready;
  plt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plt_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/plt_front.sv =====
// Front end: accept words, mark disabled and bad-type words, queue commands for the back end.
`default_nettype none
module plt_front (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             enable,
  plt_req_if.sink         req,
  output plt_pkg::cmd_t   cmd,
  output logic            cmd_valid,
  input  wire             cmd_ready
);
  import plt_pkg::*;
  localparam int QD = 2;
  cmd_t q_r [QD];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;
  cmd_t c;

  always_comb begin
    c.op = req.data.req_type;
    c.pkt_handle = req.data.pkt_handle;
    c.pkt_id = req.data.pkt_id;
    c.event_time = req.data.event_time;
    // disabled words carry an out-of-range marker code
    if (!enable) c.op = OP_DISABLED;
    else if (req.data.req_type > REQ_CLEAR) c.op = OP_BAD_REQ;
  end

  assign req.ready = (cnt_r != 2'd2);
  assign push = req.valid && req.ready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop = cmd_valid && cmd_ready;
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/plt_back.sv =====
// Back end: slot pool, in-flight list walk, completion FIFO.
`default_nettype none
module plt_back #(
  parameter int unsigned POOL_DEPTH = plt_pkg::DefPoolDepth
) (
  input  wire             clk,
  input  wire             rst_n,
  input  plt_pkg::cmd_t   cmd,
  input  wire             cmd_valid,
  output logic            cmd_ready,
  plt_rsp_if.source       rsp
);
  import plt_pkg::*;
  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ALLOC = 4'd2;
  localparam logic [3:0] S_ALLOC_W = 4'd3;
  localparam logic [3:0] S_WALK = 4'd4;
  localparam logic [3:0] S_WALK_W = 4'd5;
  localparam logic [3:0] S_CMP = 4'd6;
  localparam logic [3:0] S_FIX = 4'd7;
  localparam logic [3:0] S_RD = 4'd8;
  localparam logic [3:0] S_RD_W = 4'd9;
  localparam logic [3:0] S_RD_W2 = 4'd10;
  localparam logic [3:0] S_OUT = 4'd11;

  // memories
  logic [63:0] m_handle [POOL_DEPTH];
  logic [31:0] m_id [POOL_DEPTH];
  logic [31:0] m_start [POOL_DEPTH];
  logic [31:0] m_done [POOL_DEPTH];
  logic [10:0] m_qlen [POOL_DEPTH];
  logic [AW-1:0] m_link [POOL_DEPTH];
  logic [AW-1:0] m_fifo [POOL_DEPTH];
  logic [1:0] m_stat [POOL_DEPTH];

  logic [3:0] st_r;
  cmd_t c_r;
  logic [AW-1:0] cur_r, prev_r, head_r, tail_r, cursor_r, fifo_rd_r, idx_r;
  logic [CW-1:0] inflight_r, fifo_cnt_r, used_r, k_r;
  logic [10:0] otx_r;
  logic [AW-1:0] clr_r;
  rsp_t out_r;
  logic out_v_r;

  logic [63:0] rd_handle_r;
  logic [31:0] rd_id_r, rd_start_r, rd_done_r;
  logic [10:0] rd_qlen_r;
  logic [AW-1:0] rd_link_r, rd_fifo_r;
  logic [1:0] rd_stat_r;

  logic [AW-1:0] fifo_wr;
  logic [CW:0] fifo_sum;
  logic [31:0] match_id;

  assign fifo_sum = (CW+1)'(fifo_rd_r) + (CW+1)'(fifo_cnt_r);
  assign fifo_wr = (fifo_sum >= {1'b0, DEPTH_C}) ? AW'(fifo_sum - {1'b0, DEPTH_C})
                                                 : AW'(fifo_sum);
  assign match_id = (c_r.op == REQ_RX_DONE) ? RX_MATCH_ID : c_r.pkt_id;
  assign cmd_ready = (st_r == S_IDLE) && !out_v_r;
  assign rsp.valid = out_v_r;
  assign rsp.data = out_r;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] a);
    inc = (a == AW'(POOL_DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic rsp_t sts_word(input logic [2:0] s);
    sts_word = '0;
    sts_word.status = s;
  endfunction

  // registered reads
  always_ff @(posedge clk) begin
    rd_handle_r <= m_handle[idx_r];
    rd_id_r <= m_id[idx_r];
    rd_start_r <= m_start[idx_r];
    rd_done_r <= m_done[idx_r];
    rd_qlen_r <= m_qlen[idx_r];
    rd_link_r <= m_link[idx_r];
    rd_stat_r <= m_stat[idx_r];
    rd_fifo_r <= m_fifo[fifo_rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      clr_r <= '0;
      out_v_r <= 1'b0;
      head_r <= '0; tail_r <= '0; cursor_r <= '0; fifo_rd_r <= '0;
      inflight_r <= '0; fifo_cnt_r <= '0; used_r <= '0; otx_r <= '0;
    end else begin
      if (rsp.valid && rsp.ready) out_v_r <= 1'b0;
      case (st_r)
        S_CLR: begin
          m_stat[clr_r] <= SST_FREE;
          clr_r <= inc(clr_r);
          if (clr_r == AW'(POOL_DEPTH - 1)) st_r <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            c_r <= cmd;
            case (cmd.op)
              REQ_TX_POST, REQ_RX_START: begin
                if (used_r >= DEPTH_C) begin
                  out_r <= sts_word(STS_FULL); out_v_r <= 1'b1;
                end else begin
                  idx_r <= cursor_r; st_r <= S_ALLOC_W;
                end
              end
              REQ_TX_DONE, REQ_RX_DONE: begin
                k_r <= '0;
                idx_r <= head_r;
                cur_r <= head_r;
                if (inflight_r == '0) begin
                  out_r <= sts_word(STS_NO_MATCH); out_v_r <= 1'b1;
                end else st_r <= S_WALK_W;
              end
              REQ_READ: begin
                if (fifo_cnt_r == '0) begin
                  out_r <= sts_word(STS_EMPTY); out_v_r <= 1'b1;
                end else st_r <= S_RD_W;
              end
              REQ_CLEAR: begin
                head_r <= '0; tail_r <= '0; cursor_r <= '0; fifo_rd_r <= '0;
                inflight_r <= '0; fifo_cnt_r <= '0; used_r <= '0; otx_r <= '0;
                out_r <= sts_word(STS_OK);
                clr_r <= '0; st_r <= S_CLR; out_v_r <= 1'b1;
              end
              OP_BAD_REQ: begin
                out_r <= sts_word(STS_NO_MATCH); out_v_r <= 1'b1;
              end
              default: begin
                out_r <= sts_word(STS_DISABLED); out_v_r <= 1'b1;
              end
            endcase
          end
        end
        S_ALLOC_W: st_r <= S_ALLOC;
        S_ALLOC: begin
          if (rd_stat_r == SST_FREE) begin
            m_stat[idx_r] <= SST_INFLIGHT;
            m_handle[idx_r] <= c_r.pkt_handle;
            m_id[idx_r] <= (c_r.op == REQ_TX_POST) ? c_r.pkt_id : 32'd0;
            m_start[idx_r] <= c_r.event_time;
            if (c_r.op == REQ_TX_POST) begin
              m_qlen[idx_r] <= (otx_r < QLEN_MAX) ? otx_r + 11'd1 : otx_r;
              if (otx_r < QLEN_MAX) otx_r <= otx_r + 11'd1;
            end else m_qlen[idx_r] <= 11'd0;
            if (inflight_r == '0) head_r <= idx_r;
            else m_link[tail_r] <= idx_r;
            tail_r <= idx_r;
            inflight_r <= inflight_r + CW'(1);
            used_r <= used_r + CW'(1);
            cursor_r <= inc(idx_r);
            out_r <= sts_word(STS_OK);
            out_v_r <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            idx_r <= inc(idx_r);
            st_r <= S_ALLOC_W;
          end
        end
        S_WALK_W: st_r <= S_CMP;
        S_CMP: begin
          if (rd_handle_r == c_r.pkt_handle || rd_id_r == match_id) begin
            if (k_r == '0) head_r <= rd_link_r;
            else m_link[prev_r] <= rd_link_r;
            if (k_r + CW'(1) == inflight_r) tail_r <= prev_r;
            inflight_r <= inflight_r - CW'(1);
            m_done[cur_r] <= c_r.event_time;
            m_stat[cur_r] <= (c_r.op == REQ_RX_DONE) ? SST_DONE_RX : SST_DONE_TX;
            m_fifo[fifo_wr] <= cur_r;
            fifo_cnt_r <= fifo_cnt_r + CW'(1);
            if (c_r.op == REQ_TX_DONE && otx_r != 11'd0) otx_r <= otx_r - 11'd1;
            out_r <= sts_word(STS_OK);
            out_v_r <= 1'b1;
            st_r <= S_IDLE;
          end else if (k_r + CW'(1) == inflight_r) begin
            out_r <= sts_word(STS_NO_MATCH); out_v_r <= 1'b1;
            st_r <= S_IDLE;
          end else begin
            k_r <= k_r + CW'(1);
            prev_r <= cur_r;
            cur_r <= rd_link_r;
            idx_r <= rd_link_r;
            st_r <= S_WALK_W;
          end
        end
        S_RD_W: begin
          st_r <= S_RD_W2;
        end
        S_RD_W2: begin
          idx_r <= rd_fifo_r;
          fifo_rd_r <= inc(fifo_rd_r);
          fifo_cnt_r <= fifo_cnt_r - CW'(1);
          st_r <= S_FIX;
        end
        S_FIX: st_r <= S_RD;
        S_RD: st_r <= S_OUT;
        S_OUT: begin
          out_r <= '{status: STS_OK,
                     result_kind: (rd_stat_r == SST_DONE_RX),
                     latency: rd_done_r - rd_start_r,
                     queue_len: (rd_stat_r == SST_DONE_RX) ? 11'd0 : rd_qlen_r};
          m_stat[idx_r] <= SST_FREE;
          if (used_r != '0) used_r <= used_r - CW'(1);
          out_v_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/packet_latency_tracker.sv =====
// Top level of the packet latency tracker.
//  channel | dir | payload
//  in_     | in  | req_type, pkt_handle, pkt_id, event_time
//  out_    | out | status, result_kind, latency, queue_len
//  cfg_    | in  | monitor_enable
// One word in, one word out. Allocation scans the slot status memory slot by slot;
// completion walks the in-flight list oldest first, entry by entry; a read pops the
// completion FIFO and frees the slot. After reset and after clear, a pass over all
// slots frees the pool before the next word is taken. Stalls on out_ hold the back.
`default_nettype none
module packet_latency_tracker #(
  parameter int unsigned POOL_DEPTH = plt_pkg::DefPoolDepth
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  wire  [2:0] in_req_type,
  input  wire  [63:0] in_pkt_handle,
  input  wire  [31:0] in_pkt_id,
  input  wire  [31:0] in_event_time,
  output logic out_valid,
  input  wire  out_ready,
  output logic [2:0] out_status,
  output logic out_result_kind,
  output logic [31:0] out_latency,
  output logic [10:0] out_queue_len,
  input  wire  cfg_valid,
  output logic cfg_ready,
  input  wire  cfg_data
);
  import plt_pkg::*;
  plt_req_if req ();
  plt_rsp_if rsp ();
  cmd_t cmd;
  logic cmd_valid, cmd_ready, en_r;

  assign req.valid = in_valid;
  assign in_ready = req.ready;
  assign req.data.req_type = in_req_type;
  assign req.data.pkt_handle = in_pkt_handle;
  assign req.data.pkt_id = in_pkt_id;
  assign req.data.event_time = in_event_time;
  assign out_valid = rsp.valid;
  assign rsp.ready = out_ready;
  assign out_status = rsp.data.status;
  assign out_result_kind = rsp.data.result_kind;
  assign out_latency = rsp.data.latency;
  assign out_queue_len = rsp.data.queue_len;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) en_r <= 1'b0;
    else if (cfg_valid) en_r <= cfg_data;
  end

  plt_front u_front (
    .clk(clk), .rst_n(rst_n), .enable(en_r), .req(req.sink),
    .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
  );

  plt_back #(.POOL_DEPTH(POOL_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready), .rsp(rsp.source)
  );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the packet latency tracker.
`timescale 1ns / 1ps
module testbench;
  import plt_pkg::*;

  localparam int unsigned Depth = DefPoolDepth;
  localparam logic [2:0] REQ_RSVD_LO = 3'd6;
  localparam logic [2:0] REQ_RSVD_HI = 3'd7;

  typedef enum logic [1:0] {SLOT_FREE, SLOT_INFLIGHT, SLOT_DONE_TX, SLOT_DONE_RX} slot_state_e;
  typedef enum logic [1:0] {ACT_REQ, ACT_CFG, ACT_DRAIN} act_e;
  typedef struct {
    act_e act;
    req_t req;
    logic en;
  } plan_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  plt_req_if req_ch ();
  plt_rsp_if rsp_ch ();
  plt_cfg_if cfg_ch ();

  packet_latency_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(req_ch.valid), .in_ready(req_ch.ready),
    .in_req_type(req_ch.data.req_type), .in_pkt_handle(req_ch.data.pkt_handle),
    .in_pkt_id(req_ch.data.pkt_id), .in_event_time(req_ch.data.event_time),
    .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready),
    .out_status(rsp_ch.data.status), .out_result_kind(rsp_ch.data.result_kind),
    .out_latency(rsp_ch.data.latency), .out_queue_len(rsp_ch.data.queue_len),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_data(cfg_ch.data)
  );

  // latency tracker shadow state
  logic [63:0] sh_handle [Depth];
  logic [31:0] sh_id [Depth];
  logic [31:0] sh_start [Depth];
  logic [31:0] sh_done [Depth];
  logic [10:0] sh_qlen [Depth];
  slot_state_e sh_state [Depth];
  int unsigned sh_link [Depth];
  int unsigned sh_fifo [Depth];
  int unsigned fl_head, fl_tail, fl_count, fifo_rd, fifo_count, used_slots, tx_pending, cursor;
  logic tracking_en;

  rsp_t expected_rsp[$];
  plan_t plan[$];
  logic [63:0] handle_pool [8];
  logic [31:0] id_pool [8];
  logic [31:0] clock_now;
  logic in_taken, cfg_taken, held;
  int unsigned sent, got, cfg_writes, errors, drain_wait, hold_cnt;

  task automatic wipe_tracker();
    for (int i = 0; i < Depth; i++) begin
      sh_handle[i] = '0; sh_id[i] = '0; sh_start[i] = '0; sh_done[i] = '0;
      sh_qlen[i] = '0; sh_state[i] = SLOT_FREE; sh_link[i] = 0; sh_fifo[i] = 0;
    end
    fl_head = 0; fl_tail = 0; fl_count = 0; fifo_rd = 0; fifo_count = 0;
    used_slots = 0; tx_pending = 0; cursor = 0;
  endtask

  function automatic bit grab_slot(output int unsigned s);
    int unsigned c;
    s = 0;
    if (used_slots >= Depth) return 0;
    for (int i = 0; i < Depth; i++) begin
      c = (cursor + i) % Depth;
      if (sh_state[c] == SLOT_FREE) begin
        cursor = (c + 1) % Depth;
        sh_state[c] = SLOT_INFLIGHT;
        used_slots++;
        if (fl_count == 0) fl_head = c;
        else sh_link[fl_tail] = c;
        fl_tail = c;
        fl_count++;
        s = c;
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit retire(logic [63:0] h, logic [31:0] id, logic [31:0] t,
                                slot_state_e st);
    int unsigned cur, prev;
    cur = fl_head;
    prev = 0;
    for (int unsigned k = 0; k < fl_count; k++) begin
      if (sh_handle[cur] == h || sh_id[cur] == id) begin
        if (k == 0) fl_head = sh_link[cur];
        else sh_link[prev] = sh_link[cur];
        if (k + 1 == fl_count) fl_tail = prev;
        fl_count--;
        sh_done[cur] = t;
        sh_state[cur] = st;
        sh_fifo[(fifo_rd + fifo_count) % Depth] = cur;
        fifo_count++;
        return 1;
      end
      prev = cur;
      cur = sh_link[cur] % Depth;
    end
    return 0;
  endfunction

  task automatic track_word(input req_t r);
    rsp_t e;
    int unsigned s;
    e = '0;
    if (!tracking_en) begin
      e.status = STS_DISABLED;
    end else if (r.req_type == REQ_TX_POST || r.req_type == REQ_RX_START) begin
      if (!grab_slot(s)) begin
        e.status = STS_FULL;
      end else begin
        sh_handle[s] = r.pkt_handle;
        sh_id[s] = (r.req_type == REQ_TX_POST) ? r.pkt_id : '0;
        sh_start[s] = r.event_time;
        sh_done[s] = '0;
        if (r.req_type == REQ_TX_POST) begin
          if (tx_pending < QLEN_MAX) tx_pending++;
          sh_qlen[s] = tx_pending[10:0];
        end else begin
          sh_qlen[s] = '0;
        end
      end
    end else if (r.req_type == REQ_TX_DONE) begin
      if (!retire(r.pkt_handle, r.pkt_id, r.event_time, SLOT_DONE_TX)) e.status = STS_NO_MATCH;
      else if (tx_pending > 0) tx_pending--;
    end else if (r.req_type == REQ_RX_DONE) begin
      if (!retire(r.pkt_handle, RX_MATCH_ID, r.event_time, SLOT_DONE_RX))
        e.status = STS_NO_MATCH;
    end else if (r.req_type == REQ_READ) begin
      if (fifo_count == 0) begin
        e.status = STS_EMPTY;
      end else begin
        s = sh_fifo[fifo_rd] % Depth;
        fifo_rd = (fifo_rd + 1) % Depth;
        fifo_count--;
        e.status = STS_OK;
        e.result_kind = (sh_state[s] == SLOT_DONE_RX);
        e.latency = sh_done[s] - sh_start[s];
        e.queue_len = e.result_kind ? '0 : sh_qlen[s];
        sh_state[s] = SLOT_FREE;
        if (used_slots > 0) used_slots--;
      end
    end else if (r.req_type == REQ_CLEAR) begin
      wipe_tracker();
    end else begin
      e.status = STS_NO_MATCH;
    end
    expected_rsp.push_back(e);
  endtask

  task automatic push_req(input logic [2:0] op, input logic [63:0] h, input logic [31:0] id,
                          input logic [31:0] t);
    plan_t p;
    p.act = ACT_REQ;
    p.req = '{req_type: op, pkt_handle: h, pkt_id: id, event_time: t};
    p.en = 1'b0;
    plan.push_back(p);
  endtask

  task automatic push_cfg(input logic en);
    plan_t p;
    p.req = '0;
    p.en = en;
    p.act = ACT_DRAIN;
    plan.push_back(p);
    p.act = ACT_CFG;
    plan.push_back(p);
  endtask

  function automatic logic [63:0] pick_handle();
    if ($urandom_range(99) < 85) return handle_pool[$urandom_range(7)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return id_pool[$urandom_range(7)];
    if (r < 85) return RX_MATCH_ID;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_time();
    if ($urandom_range(99) < 80) begin
      clock_now = clock_now + $urandom_range(1, 5000);
      return clock_now;
    end
    return $urandom;
  endfunction

  task automatic build_plan();
    int unsigned r;
    logic [2:0] op;
    for (int i = 0; i < 8; i++) begin
      handle_pool[i] = {$urandom, $urandom};
      id_pool[i] = $urandom;
    end
    clock_now = $urandom;
    // disabled block answers everything as ignored
    push_req(REQ_TX_POST, 64'h1, 32'h1, 32'h0);
    push_req(REQ_READ, '0, '0, '0);
    push_req(REQ_CLEAR, '0, '0, '0);
    push_cfg(1'b1);
    push_req(REQ_TX_POST, '0, '0, 32'hFFFF_FFF0);
    push_req(REQ_TX_POST, '1, '1, 32'h5);
    push_req(REQ_RX_START, handle_pool[1], '0, 32'd100);
    push_req(REQ_TX_DONE, handle_pool[7], '0, 32'h10);
    push_req(REQ_RX_DONE, handle_pool[6], '0, 32'd20);
    push_req(REQ_TX_DONE, handle_pool[1], id_pool[5], 32'd300);
    push_req(REQ_RX_START, handle_pool[2], '0, 32'd400);
    push_req(REQ_TX_DONE, handle_pool[2], id_pool[5], 32'd350);
    push_req(REQ_TX_DONE, handle_pool[3], id_pool[4], 32'd1);
    push_req(REQ_RX_DONE, handle_pool[3], '0, 32'd1);
    for (int i = 0; i < 5; i++) push_req(REQ_READ, '0, '0, '0);
    push_req(REQ_RSVD_LO, '0, '0, '0);
    push_req(REQ_RSVD_HI, '1, '1, '1);
    push_req(REQ_TX_POST, handle_pool[4], id_pool[4], 32'd7);
    push_req(REQ_CLEAR, '0, '0, '0);
    push_req(REQ_READ, '0, '0, '0);
    // fill the pool past full
    for (int i = 0; i < Depth + 2; i++) push_req(REQ_TX_POST, {$urandom, $urandom}, i, $urandom);
    push_req(REQ_RX_START, handle_pool[0], '0, '0);
    push_req(REQ_TX_DONE, handle_pool[0], Depth - 1, $urandom);
    push_req(REQ_READ, '0, '0, '0);
    push_req(REQ_RX_START, handle_pool[0], '0, $urandom);
    push_req(REQ_CLEAR, '0, '0, '0);
    for (int i = 0; i < 850; i++) begin
      if (i % 200 == 199) push_cfg((i / 200 == 2) ? 1'b0 : 1'b1);
      r = $urandom_range(99);
      if (r < 25) op = REQ_TX_POST;
      else if (r < 35) op = REQ_RX_START;
      else if (r < 55) op = REQ_TX_DONE;
      else if (r < 65) op = REQ_RX_DONE;
      else if (r < 94) op = REQ_READ;
      else if (r < 96) op = REQ_CLEAR;
      else op = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
      push_req(op, pick_handle(), pick_id(), pick_time());
    end
    push_cfg(1'b0);
    push_req(REQ_READ, '0, '0, '0);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    rsp_ch.ready = 1'b0;
    in_taken = 1'b0;
    cfg_taken = 1'b0;
    held = 1'b0;
    sent = 0; got = 0; cfg_writes = 0; errors = 0; drain_wait = 0; hold_cnt = 0;
    tracking_en = 1'b0;
    wipe_tracker();
    build_plan();
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
  end

  always @(posedge clk) begin : sample
    rsp_t e;
    in_taken = rst_n && req_ch.valid && req_ch.ready;
    cfg_taken = rst_n && cfg_ch.valid && cfg_ch.ready;
    if (in_taken) track_word(req_ch.data);
    if (cfg_taken) begin
      tracking_en = cfg_ch.data;
      cfg_writes++;
    end
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got++;
      if (expected_rsp.size() == 0) begin
        $error("unexpected result word status %0d", rsp_ch.data.status);
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp_ch.data.status !== e.status) begin
          $error("status expected %0d got %0d", e.status, rsp_ch.data.status);
          errors++;
        end
        if (rsp_ch.data.result_kind !== e.result_kind) begin
          $error("result_kind expected %0d got %0d", e.result_kind, rsp_ch.data.result_kind);
          errors++;
        end
        if (rsp_ch.data.latency !== e.latency) begin
          $error("latency expected %0d got %0d", e.latency, rsp_ch.data.latency);
          errors++;
        end
        if (rsp_ch.data.queue_len !== e.queue_len) begin
          $error("queue_len expected %0d got %0d", e.queue_len, rsp_ch.data.queue_len);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin : drive
    logic nv, ncv, quiet;
    nv = req_ch.valid && !in_taken;
    ncv = cfg_ch.valid && !cfg_taken;
    quiet = sent >= 1300 && sent < 1700;
    if (rst_n && !nv && !ncv && plan.size() > 0) begin
      case (plan[0].act)
        ACT_DRAIN: begin
          if (expected_rsp.size() != 0) begin
            drain_wait = 0;
          end else if (drain_wait >= 30) begin
            drain_wait = 0;
            void'(plan.pop_front());
          end else begin
            drain_wait++;
          end
        end
        ACT_CFG: begin
          ncv = 1'b1;
          cfg_ch.data <= plan[0].en;
          void'(plan.pop_front());
        end
        default: begin
          if (quiet || $urandom_range(99) >= 20) begin
            nv = 1'b1;
            req_ch.data <= plan[0].req;
            void'(plan.pop_front());
            sent++;
          end
        end
      endcase
    end
    req_ch.valid <= nv;
    cfg_ch.valid <= ncv;
  end

  always @(negedge clk) begin : accept
    logic rdy;
    rdy = 1'b0;
    if (hold_cnt > 0) begin
      hold_cnt--;
    end else if (rst_n && got >= 120 && !held) begin
      held = 1'b1;
      hold_cnt = 400;
    end else if (rst_n) begin
      rdy = (sent >= 1300 && sent < 1700) || $urandom_range(99) >= 20;
    end
    rsp_ch.ready <= rdy;
  end

  initial begin
    @(posedge rst_n);
    while (plan.size() != 0 || req_ch.valid || cfg_ch.valid || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d request words and %0d enable writes, checked %0d results.",
             sent, cfg_writes, got);
    $display("Covered disabled, pool full, cross match, no match, empty and clear cases.");
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("FAILURE");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/plt_pkg.sv
rtl/plt_if.sv
rtl/plt_front.sv
rtl/plt_back.sv
rtl/packet_latency_tracker.sv
tb/testbench.sv
